// ===== sv/assert_macros.svh =====
// Assertion macros shared by the mode selector RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, masked while reset is high.
`define PMSH_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked check that also holds during reset.
`define PMSH_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== sv/pmsh_pkg.sv =====
// Types and constants for the potentiometer mode selector.
package pmsh_pkg;

  localparam int THR_W   = 10;
  localparam int CNT_W   = 16;
  localparam int DIGIT_W = 8;
  localparam int IDX_W   = 2;
  localparam int GAP     = 5;

  localparam logic [THR_W-1:0] LOW_RESET  = 10'd100;
  localparam logic [THR_W-1:0] HIGH_RESET = 10'd900;
  localparam logic [CNT_W-1:0] OVF_RESET  = 16'd0;

  localparam logic [DIGIT_W-1:0] DIG_O    = 8'h4F;
  localparam logic [DIGIT_W-1:0] DIG_F    = 8'h46;
  localparam logic [DIGIT_W-1:0] DIG_NINE = 8'd9;
  localparam logic [DIGIT_W-1:0] DIG_ONE  = 8'd1;
  localparam logic [DIGIT_W-1:0] DIG_ZERO = 8'd0;

  typedef enum logic [IDX_W-1:0] {
    REG_LOW_LEVEL = 2'd0,
    REG_HIGH_LEVEL = 2'd1,
    REG_OVF_IGNORE = 2'd2
  } reg_idx_t;

  typedef enum logic {
    CMD_SAMPLE = 1'b0,
    CMD_FAULT  = 1'b1
  } cmd_t;

  typedef enum logic [2:0] {
    MODE_OFF_S   = 3'd0,
    MODE_RUN_S   = 3'd1,
    MODE_FULL_S  = 3'd2,
    MODE_OFF_NS  = 3'd3,
    MODE_RUN_NS  = 3'd4,
    MODE_FULL_NS = 3'd5,
    MODE_FAULT   = 3'd6
  } mode_t;

  typedef enum logic [1:0] {
    HALL_KEEP    = 2'd0,
    HALL_ENABLE  = 2'd1,
    HALL_DISABLE = 2'd2
  } hall_t;

  typedef struct packed {
    logic [THR_W-1:0] low_level;
    logic [THR_W-1:0] high_level;
    logic [CNT_W-1:0] ovf_count;
  } cfg_t;

  typedef struct packed {
    mode_t mode;
    logic  arm_low;
    logic  arm_mid;
    logic  arm_high;
  } state_t;

  typedef struct packed {
    mode_t              mode;
    logic [DIGIT_W-1:0] digit_a;
    logic [DIGIT_W-1:0] digit_b;
    logic [DIGIT_W-1:0] digit_c;
    logic               display_update;
    hall_t              hall;
    logic               triacs_all_on;
    logic               percent_full;
    logic               counter_load;
    logic [CNT_W-1:0]   counter_value;
  } res_t;

endpackage

// ===== sv/pot_mode_selector_hysteresis.sv =====
// Potentiometer mode selector with hysteresis: input register, step logic, result register.
// A command waits in the input register while the result register is full and stalled.
// Throughput: one command per cycle while out_stall is low; the mode/arming update is
// a single pass of compare-and-select logic between the input and result registers.
// Reset (synchronous, rst high): mode off with sensor, all arming flags set,
// thresholds 100 and 900, reload value 0, both pipeline registers empty.
`include "assert_macros.svh"

module pot_mode_selector_hysteresis #(
  parameter int SAMPLE_BITS = 10
) (
  input  logic                         clk,
  input  logic                         rst,
  // command channel
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic                         cmd,
  input  logic [SAMPLE_BITS-1:0]       sample,
  // result channel
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [2:0]                   mode,
  output logic [SAMPLE_BITS-1:0]       level,
  output logic [pmsh_pkg::DIGIT_W-1:0] digit_a,
  output logic [pmsh_pkg::DIGIT_W-1:0] digit_b,
  output logic [pmsh_pkg::DIGIT_W-1:0] digit_c,
  output logic                         display_update,
  output logic [1:0]                   hall_irq_action,
  output logic                         triacs_all_on,
  output logic                         percent_full,
  output logic                         counter_load,
  output logic [pmsh_pkg::CNT_W-1:0]   counter_value,
  // configuration write channel
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [pmsh_pkg::IDX_W-1:0]   cfg_index,
  input  logic [pmsh_pkg::CNT_W-1:0]   cfg_data
);

  pmsh_pkg::cfg_t   cfg;
  pmsh_pkg::state_t st;
  pmsh_pkg::state_t st_next;
  pmsh_pkg::res_t   res_next;
  pmsh_pkg::res_t   res;

  logic                   in_full;
  logic                   in_cmd;
  logic [SAMPLE_BITS-1:0] in_sample;
  logic [SAMPLE_BITS-1:0] level_next;
  logic [SAMPLE_BITS-1:0] level_q;
  logic                   res_full;
  logic                   advance;
  logic                   in_take;
  logic                   out_take;

  pmsh_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  pmsh_step #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_step (
    .cmd     (in_cmd),
    .sample  (in_sample),
    .cfg     (cfg),
    .st      (st),
    .st_next (st_next),
    .res     (res_next),
    .level   (level_next)
  );

  // Advance the held command whenever the result register is free or being emptied.
  assign out_take = res_full && !out_stall;
  assign advance  = in_full && (!res_full || !out_stall);
  assign in_stall = in_full && !advance;
  assign in_take  = in_valid && !in_stall;

  // Input register: take a new beat when empty or while the previous one moves on.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_take) begin
      in_full <= 1'b1;
    end else if (advance) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_cmd    <= cmd;
      in_sample <= sample;
    end
  end

  // Mode and arming flags commit as the command leaves the input register,
  // so the next command in line already sees them.
  always_ff @(posedge clk) begin
    if (rst) begin
      st.mode     <= pmsh_pkg::MODE_OFF_S;
      st.arm_low  <= 1'b1;
      st.arm_mid  <= 1'b1;
      st.arm_high <= 1'b1;
    end else if (advance) begin
      st <= st_next;
    end
  end

  // Result register: hold the beat until the receiver drops stall.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_full <= 1'b0;
    end else if (advance) begin
      res_full <= 1'b1;
    end else if (out_take) begin
      res_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res     <= res_next;
      level_q <= level_next;
    end
  end

  assign out_valid       = res_full;
  assign mode            = res.mode;
  assign level           = level_q;
  assign digit_a         = res.digit_a;
  assign digit_b         = res.digit_b;
  assign digit_c         = res.digit_c;
  assign display_update  = res.display_update;
  assign hall_irq_action = res.hall;
  assign triacs_all_on   = res.triacs_all_on;
  assign percent_full    = res.percent_full;
  assign counter_load    = res.counter_load;
  assign counter_value   = res.counter_value;

  `PMSH_ASSERT(a_fault_cmd_sets_fault,
    in_full && advance && (in_cmd == pmsh_pkg::CMD_FAULT) |=> st.mode == pmsh_pkg::MODE_FAULT,
    "fault command did not force fault mode")
  `PMSH_ASSERT(a_one_arm_clear,
    $countones({st.arm_low, st.arm_mid, st.arm_high}) >= 2,
    "more than one arming flag cleared")
  `PMSH_ASSERT(a_stall_only_when_held,
    in_stall |-> in_full && res_full,
    "input stalled with nothing blocking")
  `PMSH_ASSERT(a_load_only_sensor_run,
    out_valid && counter_load |-> mode == pmsh_pkg::MODE_RUN_S,
    "counter reload outside sensor run")
  `PMSH_ASSERT(a_triacs_only_full,
    out_valid && triacs_all_on |->
      (mode == pmsh_pkg::MODE_FULL_S) || (mode == pmsh_pkg::MODE_FULL_NS),
    "triacs pulse outside full mode")

endmodule

// ===== sv/pmsh_cfg_regs.sv =====
// Configuration register bank: thresholds and overflow reload value.
module pmsh_cfg_regs (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [pmsh_pkg::IDX_W-1:0] cfg_index,
  input  logic [pmsh_pkg::CNT_W-1:0] cfg_data,
  output pmsh_pkg::cfg_t            cfg
);

  pmsh_pkg::cfg_t regs;

  assign cfg_ready = 1'b1;
  assign cfg       = regs;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.low_level  <= pmsh_pkg::LOW_RESET;
      regs.high_level <= pmsh_pkg::HIGH_RESET;
      regs.ovf_count  <= pmsh_pkg::OVF_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (pmsh_pkg::reg_idx_t'(cfg_index))
        pmsh_pkg::REG_LOW_LEVEL:  regs.low_level  <= cfg_data[pmsh_pkg::THR_W-1:0];
        pmsh_pkg::REG_HIGH_LEVEL: regs.high_level <= cfg_data[pmsh_pkg::THR_W-1:0];
        pmsh_pkg::REG_OVF_IGNORE: regs.ovf_count  <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

// ===== sv/pmsh_step.sv =====
// Band sort and mode transition logic for one command.
module pmsh_step #(
  parameter int SAMPLE_BITS = 10
) (
  input  logic                   cmd,
  input  logic [SAMPLE_BITS-1:0] sample,
  input  pmsh_pkg::cfg_t         cfg,
  input  pmsh_pkg::state_t       st,
  output pmsh_pkg::state_t       st_next,
  output pmsh_pkg::res_t         res,
  output logic [SAMPLE_BITS-1:0] level
);

  // Compare width: wide enough for either operand plus the gap, never wraps.
  localparam int CW = ((SAMPLE_BITS > pmsh_pkg::THR_W) ? SAMPLE_BITS : pmsh_pkg::THR_W) + 8;

  logic [CW-1:0] lv_ext;
  logic [CW-1:0] lo_ext;
  logic [CW-1:0] hi_ext;
  logic          in_low;
  logic          in_mid;
  logic          in_high;

  // All-ones minus the sample is its bitwise inverse.
  assign level  = (pmsh_pkg::cmd_t'(cmd) == pmsh_pkg::CMD_FAULT) ? '0 : ~sample;
  assign lv_ext = CW'(level);
  assign lo_ext = CW'(cfg.low_level);
  assign hi_ext = CW'(cfg.high_level);

  assign in_low  = lv_ext < lo_ext;
  assign in_mid  = (lv_ext >= lo_ext + CW'(pmsh_pkg::GAP)) &&
                   (lv_ext + CW'(pmsh_pkg::GAP) <= hi_ext);
  assign in_high = lv_ext > hi_ext;

  always_comb begin
    pmsh_pkg::state_t s;
    s   = st;
    res = '0;
    if (pmsh_pkg::cmd_t'(cmd) == pmsh_pkg::CMD_FAULT) begin
      s.mode = pmsh_pkg::MODE_FAULT;
    end else begin
      // Low band first, then middle, then high, each seeing the updated mode.
      if (in_low && s.arm_low &&
          (s.mode == pmsh_pkg::MODE_OFF_S || s.mode == pmsh_pkg::MODE_RUN_S ||
           s.mode == pmsh_pkg::MODE_FULL_S || s.mode == pmsh_pkg::MODE_RUN_NS ||
           s.mode == pmsh_pkg::MODE_FAULT)) begin
        s.mode = (s.mode == pmsh_pkg::MODE_FAULT) ? pmsh_pkg::MODE_OFF_NS
                                                   : pmsh_pkg::MODE_OFF_S;
        s.arm_low  = 1'b0;
        s.arm_mid  = 1'b1;
        s.arm_high = 1'b1;
        res.digit_a = pmsh_pkg::DIG_O;
        res.digit_b = pmsh_pkg::DIG_F;
        res.digit_c = pmsh_pkg::DIG_F;
        res.display_update = 1'b1;
      end
      if (in_mid && s.arm_mid) begin
        if (s.mode == pmsh_pkg::MODE_OFF_S || s.mode == pmsh_pkg::MODE_FULL_S) begin
          s.mode = pmsh_pkg::MODE_RUN_S;
          res.hall = pmsh_pkg::HALL_ENABLE;
          res.counter_load  = 1'b1;
          res.counter_value = cfg.ovf_count;
          s.arm_low  = 1'b1;
          s.arm_mid  = 1'b0;
          s.arm_high = 1'b1;
        end else if (s.mode == pmsh_pkg::MODE_OFF_NS ||
                     s.mode == pmsh_pkg::MODE_FULL_NS) begin
          s.mode = pmsh_pkg::MODE_RUN_NS;
          res.hall = pmsh_pkg::HALL_ENABLE;
          s.arm_low  = 1'b1;
          s.arm_mid  = 1'b0;
          s.arm_high = 1'b1;
        end
      end
      if (in_high && s.arm_high) begin
        if (s.mode == pmsh_pkg::MODE_OFF_S || s.mode == pmsh_pkg::MODE_RUN_S) begin
          s.mode = pmsh_pkg::MODE_FULL_S;
          res.hall = pmsh_pkg::HALL_DISABLE;
          res.triacs_all_on = 1'b1;
          s.arm_low  = 1'b1;
          s.arm_mid  = 1'b1;
          s.arm_high = 1'b0;
          res.digit_a = pmsh_pkg::DIG_NINE;
          res.digit_b = pmsh_pkg::DIG_NINE;
          res.digit_c = pmsh_pkg::DIG_NINE;
          res.display_update = 1'b1;
        end else if (s.mode == pmsh_pkg::MODE_OFF_NS ||
                     s.mode == pmsh_pkg::MODE_RUN_NS) begin
          s.mode = pmsh_pkg::MODE_FULL_NS;
          res.hall = pmsh_pkg::HALL_DISABLE;
          res.triacs_all_on = 1'b1;
          res.percent_full  = 1'b1;
          s.arm_low  = 1'b1;
          s.arm_mid  = 1'b1;
          s.arm_high = 1'b0;
          res.digit_a = pmsh_pkg::DIG_ONE;
          res.digit_b = pmsh_pkg::DIG_ZERO;
          res.digit_c = pmsh_pkg::DIG_ZERO;
          res.display_update = 1'b1;
        end
      end
    end
    res.mode = s.mode;
    st_next  = s;
  end

endmodule
